>>> rtl/core/bmtfr_pkg.sv
// ----------------------------------------------------------------------------
// bmtfr_pkg
// Shared types and constants for the binary image flip and rotate block.
// ----------------------------------------------------------------------------
package bmtfr_pkg;

  localparam int unsigned MaxSizeDefault = 16;

  localparam int unsigned OpW        = 2;
  localparam int unsigned RowIdxW    = 4;
  localparam int unsigned ColIdxW    = 4;
  localparam int unsigned RowBitsW   = 16;
  localparam int unsigned ImageSizeW = 5;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [ImageSizeW-1:0] ImageSizeReset = 5'd16;

  // Register index, taken from the word address bit of paddr.
  localparam logic RegIdxImageSize = 1'b0;

  typedef enum logic [OpW-1:0] {
    OP_TOGGLE = 2'd0,
    OP_FLIP   = 2'd1,
    OP_ROTATE = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef struct packed {
    op_e                operation;
    logic [RowIdxW-1:0] row_index;
    logic [ColIdxW-1:0] column_index;
  } in_item_t;

  typedef struct packed {
    logic [RowBitsW-1:0] row_bits;
    logic                rejected;
  } out_item_t;

  // Control from the sequencer to the image store.
  typedef struct packed {
    logic toggle_en;
    logic flip_en;
    logic rot_en;
    logic commit_en;
  } img_ctrl_t;

endpackage

>>> rtl/core/bmtfr_rev_unit.sv
// ----------------------------------------------------------------------------
// bmtfr_rev_unit
// Shared reversal unit: mirrors the low size bits of a row word.
// ----------------------------------------------------------------------------
module bmtfr_rev_unit #(
  parameter int unsigned MAX_SIZE = bmtfr_pkg::MaxSizeDefault
) (
  input  logic [MAX_SIZE-1:0]              data_i,
  input  logic [$clog2(MAX_SIZE+1)-1:0]    size_i,
  output logic [MAX_SIZE-1:0]              data_o
);

  localparam int unsigned SizeW = $clog2(MAX_SIZE + 1);

  logic [MAX_SIZE-1:0] full_rev;
  logic [SizeW-1:0]    shamt;

  // A full reversal puts bit c at MAX_SIZE-1-c; shifting right by
  // MAX_SIZE-size lands it at size-1-c and drops bits at or beyond size.
  always_comb begin
    for (int c = 0; c < MAX_SIZE; c++) begin
      full_rev[c] = data_i[MAX_SIZE-1-c];
    end
  end

  assign shamt  = SizeW'(MAX_SIZE) - size_i;
  assign data_o = full_rev >> shamt;

endmodule

>>> rtl/core/bmtfr_image.sv
// ----------------------------------------------------------------------------
// bmtfr_image
// Pixel row store with a staging bank for rotation and the reversal unit.
// ----------------------------------------------------------------------------
module bmtfr_image #(
  parameter int unsigned MAX_SIZE = bmtfr_pkg::MaxSizeDefault
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  bmtfr_pkg::img_ctrl_t                          ctrl_i,
  input  logic [$clog2(MAX_SIZE+1)-1:0]                 size_i,
  input  logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1)-1:0] step_i,
  input  logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1)-1:0] row_addr_i,
  input  logic [bmtfr_pkg::ColIdxW-1:0]                 col_i,
  output logic [MAX_SIZE-1:0]                           rd_row_o
);

  localparam int unsigned SizeW = $clog2(MAX_SIZE + 1);

  logic [MAX_SIZE-1:0] rows_q [MAX_SIZE];
  logic [MAX_SIZE-1:0] tmp_q  [MAX_SIZE];
  logic [MAX_SIZE-1:0] live_mask;
  logic [MAX_SIZE-1:0] col_bits;
  logic [MAX_SIZE-1:0] rev_in;
  logic [MAX_SIZE-1:0] rev_out;
  logic [MAX_SIZE-1:0] bit_one;
  logic [MAX_SIZE-1:0] tog_mask;

  // live_mask serves both as the column mask and as the row enable.
  always_comb begin
    for (int k = 0; k < MAX_SIZE; k++) begin
      live_mask[k] = (SizeW'(k) < size_i);
      col_bits[k]  = rows_q[k][step_i];
    end
  end

  always_comb begin
    bit_one    = '0;
    bit_one[0] = 1'b1;
    tog_mask   = bit_one << col_i;
  end

  // Rotation builds new row r from column r of the old image, reversed.
  assign rev_in = ctrl_i.flip_en ? rows_q[step_i] : col_bits;

  bmtfr_rev_unit #(
    .MAX_SIZE(MAX_SIZE)
  ) u_rev (
    .data_i(rev_in),
    .size_i(size_i),
    .data_o(rev_out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_SIZE; k++) begin
        rows_q[k] <= '0;
      end
    end else begin
      if (ctrl_i.toggle_en) begin
        rows_q[row_addr_i] <= rows_q[row_addr_i] ^ tog_mask;
      end
      if (ctrl_i.flip_en) begin
        rows_q[step_i] <= (rows_q[step_i] & ~live_mask) | rev_out;
      end
      if (ctrl_i.commit_en) begin
        for (int k = 0; k < MAX_SIZE; k++) begin
          if (live_mask[k]) begin
            rows_q[k] <= (rows_q[k] & ~live_mask) | tmp_q[k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rot_en) begin
      tmp_q[step_i] <= rev_out;
    end
  end

  assign rd_row_o = rows_q[row_addr_i] & live_mask;

endmodule

>>> rtl/core/bit_matrix_toggle_flip_rotate.sv
// ----------------------------------------------------------------------------
// bit_matrix_toggle_flip_rotate: toggle and read show their result in the cycle
// after acceptance. Flip walks the rows in ST_FLIP, rotate in ST_ROT and then
// ST_COMMIT, one row per pass through the shared reversal unit; input is not
// ready until the result is loaded, and the next transaction can be accepted
// in the cycle the result is taken.
// Reset clears the image to zeros and sets image_size to 16; no clearing pass.
// ----------------------------------------------------------------------------
module bit_matrix_toggle_flip_rotate #(
  parameter int unsigned MAX_SIZE = bmtfr_pkg::MaxSizeDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  bmtfr_pkg::in_item_t               in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output bmtfr_pkg::out_item_t              out_item_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bmtfr_pkg::CfgAddrW-1:0]    paddr,
  input  logic [bmtfr_pkg::CfgDataW-1:0]    pwdata,
  output logic [bmtfr_pkg::CfgDataW-1:0]    prdata,
  output logic                              pready
);

  localparam int unsigned SizeW = $clog2(MAX_SIZE + 1);
  localparam int unsigned IdxW  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_FLIP   = 4'b0010,
    ST_ROT    = 4'b0100,
    ST_COMMIT = 4'b1000
  } state_e;

  state_e                                  state_q, state_d;
  logic [IdxW-1:0]                         step_q, step_d;
  logic [bmtfr_pkg::ImageSizeW-1:0]        image_size_q;
  logic                                    out_valid_q, out_valid_d;
  bmtfr_pkg::out_item_t                    out_item_q, out_item_d;

  logic                 cfg_write;
  logic [SizeW-1:0]     size_n;
  logic                 in_fire;
  logic                 step_last;
  logic                 row_rej;
  logic                 col_rej;
  logic [31:0]          row_ext;
  logic [31:0]          rd_ext;
  logic [IdxW-1:0]      row_addr;
  logic [MAX_SIZE-1:0]  rd_row;
  logic                 load_out;
  bmtfr_pkg::img_ctrl_t img_ctrl;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == bmtfr_pkg::RegIdxImageSize);
  assign prdata    = (paddr[2] == bmtfr_pkg::RegIdxImageSize) ?
                     bmtfr_pkg::CfgDataW'(image_size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_size_q <= bmtfr_pkg::ImageSizeReset;
    end else if (cfg_write) begin
      image_size_q <= pwdata[bmtfr_pkg::ImageSizeW-1:0];
    end
  end

  // A size of zero acts as one; sizes above the storage act as the maximum.
  always_comb begin
    if (image_size_q == '0) begin
      size_n = SizeW'(1);
    end else if (32'(image_size_q) > MAX_SIZE) begin
      size_n = SizeW'(MAX_SIZE);
    end else begin
      size_n = SizeW'(image_size_q);
    end
  end

  assign row_ext  = 32'(in_item_i.row_index);
  assign row_addr = row_ext[IdxW-1:0];
  assign row_rej  = row_ext >= 32'(size_n);
  assign col_rej  = 32'(in_item_i.column_index) >= 32'(size_n);
  assign rd_ext   = 32'(rd_row);

  assign step_last  = (32'(step_q) + 32'd1) == 32'(size_n);
  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    img_ctrl   = '0;
    load_out   = 1'b0;
    out_item_d = out_item_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_item_i.operation)
            bmtfr_pkg::OP_TOGGLE: begin
              img_ctrl.toggle_en  = !(row_rej || col_rej);
              load_out            = 1'b1;
              out_item_d.row_bits = '0;
              out_item_d.rejected = row_rej || col_rej;
            end
            bmtfr_pkg::OP_FLIP: begin
              state_d = ST_FLIP;
              step_d  = '0;
            end
            bmtfr_pkg::OP_ROTATE: begin
              state_d = ST_ROT;
              step_d  = '0;
            end
            bmtfr_pkg::OP_READ: begin
              load_out            = 1'b1;
              out_item_d.row_bits = row_rej ? '0 : rd_ext[bmtfr_pkg::RowBitsW-1:0];
              out_item_d.rejected = row_rej;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_FLIP: begin
        img_ctrl.flip_en = 1'b1;
        if (step_last) begin
          state_d  = ST_IDLE;
          load_out = 1'b1;
          out_item_d = '0;
        end else begin
          step_d = step_q + IdxW'(1);
        end
      end
      ST_ROT: begin
        img_ctrl.rot_en = 1'b1;
        if (step_last) begin
          state_d = ST_COMMIT;
        end else begin
          step_d = step_q + IdxW'(1);
        end
      end
      ST_COMMIT: begin
        img_ctrl.commit_en = 1'b1;
        state_d    = ST_IDLE;
        load_out   = 1'b1;
        out_item_d = '0;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Flip and rotate start only with the output slot free, so it is still
  // free when their result is loaded.
  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  bmtfr_image #(
    .MAX_SIZE(MAX_SIZE)
  ) u_image (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (img_ctrl),
    .size_i    (size_n),
    .step_i    (step_q),
    .row_addr_i(row_addr),
    .col_i     (in_item_i.column_index),
    .rd_row_o  (rd_row)
  );

`ifndef SYNTH
  // The row counter never walks past the image in use.
  a_step_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLIP || state_q == ST_ROT) |-> (32'(step_q) < 32'(size_n)))
    else $error("row counter beyond image size");

  // A commit always finishes the rotation and delivers its result.
  a_commit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMMIT) |=> (state_q == ST_IDLE && out_valid_q))
    else $error("rotation commit did not deliver a result");

  // Flip and rotate never show a result in the cycle after they start.
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_item_i.operation == bmtfr_pkg::OP_FLIP ||
                 in_item_i.operation == bmtfr_pkg::OP_ROTATE)) |=> !out_valid_q)
    else $error("early result for a multi-cycle transaction");
`endif

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for bit_matrix_toggle_flip_rotate
// Drives toggle, flip, rotate and read operations through the valid/ready
// input channel while the image size is changed over the APB port between
// phases. Each transaction is checked against a set result or a local image
// model with its own copy of the pixel rows and size register. Directed rows
// come first, then random phases with idle gaps on both channels.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned ImgMax = bmtfr_pkg::MaxSizeDefault;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned NumPhases = 24;
  localparam int unsigned ItemsPerPhase = 80;
  localparam logic [bmtfr_pkg::CfgAddrW-1:0] ImageSizeAddr =
    {bmtfr_pkg::RegIdxImageSize, 2'b00};

  typedef struct {
    logic                             is_cfg;
    logic [bmtfr_pkg::ImageSizeW-1:0] cfg_val;
    bmtfr_pkg::in_item_t              item;
    logic                             fixed;
    bmtfr_pkg::out_item_t             fixed_res;
  } directed_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready_o;
  bmtfr_pkg::in_item_t in_item = '0;
  logic out_valid_o;
  logic out_ready = 1'b0;
  bmtfr_pkg::out_item_t out_item_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [bmtfr_pkg::CfgAddrW-1:0] paddr = '0;
  logic [bmtfr_pkg::CfgDataW-1:0] pwdata = '0;
  logic [bmtfr_pkg::CfgDataW-1:0] prdata;
  logic pready;

  // Local image model.
  logic [bmtfr_pkg::RowBitsW-1:0]   img_rows [ImgMax];
  logic [bmtfr_pkg::ImageSizeW-1:0] img_size;

  bmtfr_pkg::out_item_t pending_results [$];
  directed_row_t        directed_ops [$];
  int unsigned          err_count = 0;
  int unsigned          cycle_cnt = 0;

  bit_matrix_toggle_flip_rotate dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("FAIL bit_matrix_toggle_flip_rotate");
      $finish;
    end
  end

  function automatic void note_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endfunction

  function automatic int unsigned active_size();
    if (img_size == 0) return 1;
    if (img_size > ImgMax) return ImgMax;
    return img_size;
  endfunction

  // Applies one operation to the model image and returns its result.
  function automatic bmtfr_pkg::out_item_t image_apply(input bmtfr_pkg::in_item_t it);
    bmtfr_pkg::out_item_t           res;
    int unsigned                    n;
    logic [bmtfr_pkg::RowBitsW-1:0] m;
    logic [bmtfr_pkg::RowBitsW-1:0] rev;
    logic [bmtfr_pkg::RowBitsW-1:0] turned [ImgMax];
    n = active_size();
    m = bmtfr_pkg::RowBitsW'((17'd1 << n) - 17'd1);
    res = '0;
    case (it.operation)
      bmtfr_pkg::OP_TOGGLE: begin
        if (it.row_index >= n || it.column_index >= n) begin
          res.rejected = 1'b1;
        end else begin
          img_rows[it.row_index][it.column_index] = ~img_rows[it.row_index][it.column_index];
        end
      end
      bmtfr_pkg::OP_FLIP: begin
        for (int r = 0; r < n; r++) begin
          rev = '0;
          for (int c = 0; c < n; c++) rev[n-1-c] = img_rows[r][c];
          img_rows[r] = (img_rows[r] & ~m) | rev;
        end
      end
      bmtfr_pkg::OP_ROTATE: begin
        // new(r,c) = old(n-1-c, r); pixels outside the square stay put.
        for (int r = 0; r < n; r++) begin
          turned[r] = '0;
          for (int c = 0; c < n; c++) turned[r][c] = img_rows[n-1-c][r];
        end
        for (int r = 0; r < n; r++) img_rows[r] = (img_rows[r] & ~m) | turned[r];
      end
      default: begin
        if (it.row_index >= n) res.rejected = 1'b1;
        else res.row_bits = img_rows[it.row_index] & m;
      end
    endcase
    return res;
  endfunction

  function automatic directed_row_t step_row(input bmtfr_pkg::op_e op, input int row,
                                             input int col, input logic fixed,
                                             input logic [bmtfr_pkg::RowBitsW-1:0] bits,
                                             input logic rej);
    directed_row_t d;
    d.is_cfg = 1'b0;
    d.cfg_val = '0;
    d.item.operation = op;
    d.item.row_index = bmtfr_pkg::RowIdxW'(row);
    d.item.column_index = bmtfr_pkg::ColIdxW'(col);
    d.fixed = fixed;
    d.fixed_res.row_bits = bits;
    d.fixed_res.rejected = rej;
    return d;
  endfunction

  function automatic directed_row_t cfg_row(input int unsigned value);
    directed_row_t d;
    d = step_row(bmtfr_pkg::OP_READ, 0, 0, 1'b0, '0, 1'b0);
    d.is_cfg = 1'b1;
    d.cfg_val = bmtfr_pkg::ImageSizeW'(value);
    return d;
  endfunction

  function automatic int unsigned pick_gap(input logic burst);
    int unsigned p;
    if (burst) return 0;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic int unsigned pick_size();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 70) return $urandom_range(1, 16);
    if (p < 80) return 16;
    if (p < 90) return 0;
    return $urandom_range(17, 31);
  endfunction

  function automatic bmtfr_pkg::in_item_t rand_item(input int unsigned n);
    bmtfr_pkg::in_item_t it;
    int unsigned         p;
    p = $urandom_range(99);
    if (p < 40) it.operation = bmtfr_pkg::OP_TOGGLE;
    else if (p < 75) it.operation = bmtfr_pkg::OP_READ;
    else if (p < 87) it.operation = bmtfr_pkg::OP_FLIP;
    else it.operation = bmtfr_pkg::OP_ROTATE;
    // Mostly in-range indexes so the image fills up; some land anywhere.
    if ($urandom_range(9) == 0) begin
      it.row_index = bmtfr_pkg::RowIdxW'($urandom_range(15));
      it.column_index = bmtfr_pkg::ColIdxW'($urandom_range(15));
    end else begin
      it.row_index = bmtfr_pkg::RowIdxW'($urandom_range(n - 1));
      it.column_index = bmtfr_pkg::ColIdxW'($urandom_range(n - 1));
    end
    return it;
  endfunction

  // Holds valid until the transaction is accepted, then records its result.
  task automatic send_item(input bmtfr_pkg::in_item_t it, input logic fixed,
                           input bmtfr_pkg::out_item_t fixed_res);
    bmtfr_pkg::out_item_t pred;
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready_o);
    pred = image_apply(it);
    pending_results.push_back(fixed ? fixed_res : pred);
  endtask

  task automatic idle_gap(input logic burst);
    int unsigned gap;
    gap = pick_gap(burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Write followed by a read-back; psel stays high across both transfers.
  task automatic write_image_size(input logic [bmtfr_pkg::ImageSizeW-1:0] value);
    logic [bmtfr_pkg::CfgDataW-1:0] rd;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ImageSizeAddr;
    pwdata <= bmtfr_pkg::CfgDataW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    img_size = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd !== bmtfr_pkg::CfgDataW'(value)) begin
      note_error($sformatf("image_size read-back: expected %0d, got 0x%0h", value, rd));
    end
  endtask

  // Result side: runs of ready alternate with stalls, mostly short ones.
  logic        ready_mode = 1'b0;
  int unsigned ready_run = 0;
  always @(posedge clk) begin
    if (ready_run == 0) begin
      ready_mode = !ready_mode;
      if (ready_mode) begin
        ready_run = ($urandom_range(9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 20);
      end else begin
        ready_run = ($urandom_range(9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
      end
    end
    ready_run--;
    out_ready <= ready_mode;
  end

  always @(posedge clk) begin
    bmtfr_pkg::out_item_t want;
    if (rst_n && out_valid_o && out_ready) begin
      if (pending_results.size() == 0) begin
        note_error($sformatf("unexpected result: row_bits 0x%04h rejected %0b",
                             out_item_o.row_bits, out_item_o.rejected));
      end else begin
        want = pending_results.pop_front();
        if (out_item_o.row_bits !== want.row_bits) begin
          note_error($sformatf("row_bits mismatch: expected 0x%04h, got 0x%04h",
                               want.row_bits, out_item_o.row_bits));
        end
        if (out_item_o.rejected !== want.rejected) begin
          note_error($sformatf("rejected mismatch: expected %0b, got %0b",
                               want.rejected, out_item_o.rejected));
        end
      end
    end
  end

  initial begin
    directed_row_t       d;
    bmtfr_pkg::in_item_t it;
    int unsigned         n;
    logic                burst;

    for (int r = 0; r < ImgMax; r++) img_rows[r] = '0;
    img_size = bmtfr_pkg::ImageSizeReset;

    directed_ops.push_back(step_row(bmtfr_pkg::OP_READ, 0, 0, 1'b1, 16'h0000, 1'b0));
    directed_ops.push_back(step_row(bmtfr_pkg::OP_READ, 15, 15, 1'b1, 16'h0000, 1'b0));
    directed_ops.push_back(step_row(bmtfr_pkg::OP_TOGGLE, 0, 0, 1'b1, 16'h0000, 1'b0));
    directed_ops.push_back(step_row(bmtfr_pkg::OP_TOGGLE, 15, 15, 1'b1, 16'h0000, 1'b0));
    directed_ops.push_back(step_row(bmtfr_pkg::OP_TOGGLE, 0, 15, 1'b1, 16'h0000, 1'b0));
    directed_ops.push_back(step_row(bmtfr_pkg::OP_READ, 0, 9, 1'b1, 16'h8001, 1'b0));
    directed_ops.push_back(step_row(bmtfr_pkg::OP_READ, 15, 0, 1'b1, 16'h8000, 1'b0));
    directed_ops.push_back(step_row(bmtfr_pkg::OP_FLIP, 3, 4, 1'b1, 16'h0000, 1'b0));
    directed_ops.push_back(step_row(bmtfr_pkg::OP_READ, 15, 0, 1'b0, '0, 1'b0));
    directed_ops.push_back(step_row(bmtfr_pkg::OP_ROTATE, 9, 2, 1'b1, 16'h0000, 1'b0));
    directed_ops.push_back(step_row(bmtfr_pkg::OP_READ, 0, 0, 1'b0, '0, 1'b0));
    directed_ops.push_back(step_row(bmtfr_pkg::OP_READ, 15, 0, 1'b0, '0, 1'b0));
    directed_ops.push_back(step_row(bmtfr_pkg::OP_TOGGLE, 7, 8, 1'b1, 16'h0000, 1'b0));
    directed_ops.push_back(step_row(bmtfr_pkg::OP_TOGGLE, 8, 7, 1'b1, 16'h0000, 1'b0));
    directed_ops.push_back(step_row(bmtfr_pkg::OP_ROTATE, 0, 0, 1'b1, 16'h0000, 1'b0));
    directed_ops.push_back(step_row(bmtfr_pkg::OP_READ, 7, 0, 1'b0, '0, 1'b0));
    directed_ops.push_back(step_row(bmtfr_pkg::OP_READ, 8, 0, 1'b0, '0, 1'b0));
    // Even size: the middle pair of each row must end up swapped.
    directed_ops.push_back(step_row(bmtfr_pkg::OP_FLIP, 0, 0, 1'b1, 16'h0000, 1'b0));
    directed_ops.push_back(step_row(bmtfr_pkg::OP_READ, 7, 15, 1'b0, '0, 1'b0));
    directed_ops.push_back(cfg_row(1));
    directed_ops.push_back(step_row(bmtfr_pkg::OP_TOGGLE, 0, 1, 1'b1, 16'h0000, 1'b1));
    directed_ops.push_back(step_row(bmtfr_pkg::OP_TOGGLE, 1, 0, 1'b1, 16'h0000, 1'b1));
    directed_ops.push_back(step_row(bmtfr_pkg::OP_TOGGLE, 15, 15, 1'b1, 16'h0000, 1'b1));
    directed_ops.push_back(step_row(bmtfr_pkg::OP_READ, 1, 0, 1'b1, 16'h0000, 1'b1));
    directed_ops.push_back(step_row(bmtfr_pkg::OP_READ, 0, 0, 1'b0, '0, 1'b0));
    directed_ops.push_back(step_row(bmtfr_pkg::OP_FLIP, 0, 0, 1'b1, 16'h0000, 1'b0));
    directed_ops.push_back(step_row(bmtfr_pkg::OP_ROTATE, 0, 0, 1'b1, 16'h0000, 1'b0));
    // A size of zero acts as one, anything above the maximum as the maximum.
    directed_ops.push_back(cfg_row(0));
    directed_ops.push_back(step_row(bmtfr_pkg::OP_TOGGLE, 0, 0, 1'b1, 16'h0000, 1'b0));
    directed_ops.push_back(step_row(bmtfr_pkg::OP_READ, 0, 0, 1'b0, '0, 1'b0));
    directed_ops.push_back(cfg_row(31));
    directed_ops.push_back(step_row(bmtfr_pkg::OP_READ, 15, 0, 1'b0, '0, 1'b0));
    directed_ops.push_back(step_row(bmtfr_pkg::OP_TOGGLE, 15, 0, 1'b1, 16'h0000, 1'b0));

    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_ops[i]) begin
      d = directed_ops[i];
      if (d.is_cfg) begin
        wait_idle();
        write_image_size(d.cfg_val);
      end else begin
        send_item(d.item, d.fixed, d.fixed_res);
        idle_gap(1'b0);
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_idle();
      if (ph == 0) write_image_size(bmtfr_pkg::ImageSizeW'(16));
      else if (ph == 1) write_image_size(bmtfr_pkg::ImageSizeW'(2));
      else write_image_size(bmtfr_pkg::ImageSizeW'(pick_size()));
      n = active_size();
      burst = ($urandom_range(3) == 0);
      for (int k = 0; k < ItemsPerPhase; k++) begin
        if (ph == 3 && k == ItemsPerPhase / 2) wait_idle();
        it = rand_item(n);
        send_item(it, 1'b0, '0);
        idle_gap(burst);
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS bit_matrix_toggle_flip_rotate");
    end else begin
      $display("FAIL bit_matrix_toggle_flip_rotate");
    end
    $finish;
  end

endmodule
